// ===== rtl/rau_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit package
// Shared widths, mode and error codes, and the item and queue entry types.
// ----------------------------------------------------------------------------
package rau_pkg;

    localparam int unsigned DefWidth = 32;
    localparam int unsigned FieldW   = 32;
    localparam int unsigned MagW     = 66;

    typedef enum logic [3:0] {
        MODE_ADD    = 4'd0,
        MODE_SUB    = 4'd1,
        MODE_MUL    = 4'd2,
        MODE_DIV    = 4'd3,
        MODE_NEG    = 4'd4,
        MODE_INC    = 4'd5,
        MODE_CMP    = 4'd6,
        MODE_RED    = 4'd7,
        MODE_TOINT  = 4'd8
    } mode_e;

    localparam logic [1:0] ERR_OK   = 2'd0;
    localparam logic [1:0] ERR_ZDEN = 2'd1;
    localparam logic [1:0] ERR_OVF  = 2'd2;

    typedef struct packed {
        logic [3:0]         mode;
        logic signed [31:0] a_num;
        logic signed [31:0] a_den;
        logic signed [31:0] b_num;
        logic signed [31:0] b_den;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] res_num;
        logic [30:0]        res_den;
        logic               is_less;
        logic               is_equal;
        logic               is_greater;
        logic [1:0]         error;
    } out_item_t;

    // Decoded operands in sign and magnitude form.
    typedef struct packed {
        logic [3:0]  mode;
        logic        a_neg;
        logic [32:0] a_n;
        logic [32:0] a_d;
        logic        b_neg;
        logic [32:0] b_n;
        logic [32:0] b_d;
    } job_t;

endpackage
`default_nettype wire

// ===== rtl/rational_arith_unit_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit
// Exact fraction arithmetic with gcd reduction behind a two-entry queue.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; busy rises only when
// the two-entry queue is full. Each result appears for one cycle with done
// high and must be captured then. All divisions run on the shared restoring
// divider. Reducing modes run one division per modulo step of the Euclidean
// gcd and then two more to reduce numerator and denominator. Truncation to
// integer takes two divisions. Compare and unused modes skip the divider.
// An item waiting in the queue adds the time of the items ahead of it.
module rational_arith_unit_top #(
    parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire rau_pkg::in_item_t  in_item,
    output logic                    done,
    output rau_pkg::out_item_t      result
);
    import rau_pkg::*;

    logic q_valid;
    logic q_pop;
    job_t q_job;

    rau_front #(.WIDTH(WIDTH)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .in_item (in_item),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop)
    );

    rau_back #(.WIDTH(WIDTH)) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_valid (q_valid),
        .q_job   (q_job),
        .q_pop   (q_pop),
        .done    (done),
        .result  (result)
    );

endmodule
`default_nettype wire

// ===== rtl/rau_front.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit front end
// Accepts items, decodes operands to sign and magnitude and queues them.
// ----------------------------------------------------------------------------
module rau_front #(
    parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             start,
    output logic                  busy,
    input  wire rau_pkg::in_item_t in_item,
    output logic                  q_valid,
    output rau_pkg::job_t         q_job,
    input  wire logic             q_pop
);
    import rau_pkg::*;

    localparam int unsigned Depth = 2;

    job_t       mem_reg [Depth];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       push;
    job_t       job_new;

    function automatic logic [32:0] mag_of(input logic [31:0] raw, output logic neg);
        logic [31:0] v;
        logic        s;
        begin
            v = raw;
            s = raw[WIDTH-1];
            for (int i = 0; i < 32; i++)
            begin
                if (i >= WIDTH)
                begin
                    v[i] = s;
                end
            end
            neg = s;
            mag_of = s ? (33'd0 - {v[31], v}) : {1'b0, v};
        end
    endfunction

    always_comb
    begin
        logic an, ad, bn, bd;
        job_new.mode = in_item.mode;
        job_new.a_n  = mag_of(in_item.a_num, an);
        job_new.a_d  = mag_of(in_item.a_den, ad);
        job_new.b_n  = mag_of(in_item.b_num, bn);
        job_new.b_d  = mag_of(in_item.b_den, bd);
        job_new.a_neg = an ^ ad;
        job_new.b_neg = bn ^ bd;
    end

    assign busy    = (cnt_reg == 2'(Depth));
    assign push    = start && !busy;
    assign q_valid = (cnt_reg != 2'd0);
    assign q_job   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ q_pop;
        cnt_next    = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= job_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> q_valid) else $error("pop from empty queue");
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= 2'(Depth)) else $error("queue count out of range");
    a_push_cnt: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !q_pop) |=> cnt_reg == $past(cnt_reg) + 2'd1)
        else $error("queue count did not follow push");

endmodule
`default_nettype wire

// ===== rtl/rau_divider.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit divider
// Restoring divider, one quotient bit per cycle, shared by gcd and reduction.
// ----------------------------------------------------------------------------
module rau_divider (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      go,
    input  wire logic [rau_pkg::MagW-1:0]  dividend,
    input  wire logic [rau_pkg::MagW-1:0]  divisor,
    output logic                           done,
    output logic [rau_pkg::MagW-1:0]       quot,
    output logic [rau_pkg::MagW-1:0]       rem
);
    import rau_pkg::*;

    logic [MagW-1:0] q_reg, q_next;
    logic [MagW-1:0] r_reg, r_next;
    logic [MagW-1:0] d_reg, d_next;
    logic [6:0]      cnt_reg, cnt_next;
    logic            run_reg, run_next;
    logic            done_reg, done_next;
    logic [MagW:0]   trial;

    assign quot = q_reg;
    assign rem  = r_reg;
    assign done = done_reg;
    assign trial = {r_reg, q_reg[MagW-1]} - {1'b0, d_reg};

    always_comb
    begin
        q_next = q_reg;
        r_next = r_reg;
        d_next = d_reg;
        cnt_next = cnt_reg;
        run_next = run_reg;
        done_next = 1'b0;
        if (go)
        begin
            q_next = dividend;
            r_next = '0;
            d_next = divisor;
            cnt_next = 7'(MagW);
            run_next = 1'b1;
        end
        else if (run_reg)
        begin
            if (!trial[MagW])
            begin
                r_next = trial[MagW-1:0];
                q_next = {q_reg[MagW-2:0], 1'b1};
            end
            else
            begin
                r_next = {r_reg[MagW-2:0], q_reg[MagW-1]};
                q_next = {q_reg[MagW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd1)
            begin
                run_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    a_done_after_run: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !run_reg) else $error("done while still running");
    a_go_starts: assert property (@(posedge clk) disable iff (!rst_n)
        go |=> run_reg && cnt_reg == 7'(MagW)) else $error("divider did not start");
    a_done_once: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done held longer than a cycle");

endmodule
`default_nettype wire

// ===== rtl/rau_back.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Rational arithmetic unit back end
// Forms cross products, runs the gcd and reduction on the divider, and
// checks ranges before a result is presented.
// ----------------------------------------------------------------------------
module rau_back #(
    parameter int unsigned WIDTH = rau_pkg::DefWidth
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               q_valid,
    input  wire rau_pkg::job_t      q_job,
    output logic                    q_pop,
    output logic                    done,
    output rau_pkg::out_item_t      result
);
    import rau_pkg::*;

    typedef enum logic [10:0] {
        ST_IDLE  = 11'b00000000001,
        ST_MUL1  = 11'b00000000010,
        ST_MUL2  = 11'b00000000100,
        ST_FORM  = 11'b00000001000,
        ST_GCD   = 11'b00000010000,
        ST_GWAIT = 11'b00000100000,
        ST_DIVN  = 11'b00001000000,
        ST_WN    = 11'b00010000000,
        ST_DIVD  = 11'b00100000000,
        ST_WD    = 11'b01000000000,
        ST_OUT   = 11'b10000000000
    } state_e;

    state_e          st_reg, st_next;
    job_t            job_reg, job_next;
    logic [65:0]     p1_reg, p1_next;
    logic [65:0]     p2_reg, p2_next;
    logic [65:0]     pd_reg, pd_next;
    logic            neg_reg, neg_next;
    logic [65:0]     nm_reg, nm_next;
    logic [65:0]     dm_reg, dm_next;
    logic [65:0]     gx_reg, gx_next;
    logic [65:0]     gy_reg, gy_next;
    out_item_t       res_reg, res_next;
    logic            done_reg, done_next;

    logic            dv_go;
    logic [65:0]     dv_a, dv_b;
    logic            dv_done;
    logic [65:0]     dv_q, dv_r;

    logic [65:0]     lim_pos;
    logic [65:0]     lim_den;

    rau_divider u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (dv_go),
        .dividend (dv_a),
        .divisor  (dv_b),
        .done     (dv_done),
        .quot     (dv_q),
        .rem      (dv_r)
    );

    assign lim_pos = 66'd1 << (WIDTH - 1);
    assign lim_den = lim_pos - 66'd1;
    assign done    = done_reg;
    assign result  = res_reg;

    function automatic logic [31:0] neg32(input logic neg, input logic [65:0] mag);
        logic [65:0] v;
        begin
            v = neg ? (66'd0 - mag) : mag;
            neg32 = v[31:0];
        end
    endfunction

    always_comb
    begin
        logic [65:0] sum;
        logic        sneg;
        logic        ovf;
        logic        yneg;
        logic        fneg;
        st_next   = st_reg;
        job_next  = job_reg;
        p1_next   = p1_reg;
        p2_next   = p2_reg;
        pd_next   = pd_reg;
        neg_next  = neg_reg;
        nm_next   = nm_reg;
        dm_next   = dm_reg;
        gx_next   = gx_reg;
        gy_next   = gy_reg;
        res_next  = res_reg;
        done_next = 1'b0;
        q_pop     = 1'b0;
        dv_go     = 1'b0;
        dv_a      = gx_reg;
        dv_b      = gy_reg;
        sum       = '0;
        sneg      = 1'b0;
        ovf       = 1'b0;
        yneg      = 1'b0;
        fneg      = 1'b0;
        unique case (st_reg)
            ST_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop    = 1'b1;
                    job_next = q_job;
                    st_next  = ST_MUL1;
                end
            end
            ST_MUL1:
            begin
                // Products of 33-bit magnitudes; each is a single 33x33 multiply.
                unique case (job_reg.mode)
                    MODE_MUL:
                    begin
                        p1_next = 66'(job_reg.a_n * job_reg.b_n);
                        p2_next = '0;
                    end
                    MODE_DIV:
                    begin
                        p1_next = 66'(job_reg.a_n * job_reg.b_d);
                        p2_next = '0;
                    end
                    default:
                    begin
                        p1_next = 66'(job_reg.a_n * job_reg.b_d);
                        p2_next = '0;
                    end
                endcase
                st_next = ST_MUL2;
            end
            ST_MUL2:
            begin
                if (job_reg.mode == MODE_DIV)
                begin
                    pd_next = 66'(job_reg.a_d * job_reg.b_n);
                end
                else
                begin
                    pd_next = 66'(job_reg.a_d * job_reg.b_d);
                end
                p2_next = 66'(job_reg.b_n * job_reg.a_d);
                st_next = ST_FORM;
            end
            ST_FORM:
            begin
                res_next = '0;
                st_next  = ST_GCD;
                unique case (job_reg.mode)
                    MODE_ADD, MODE_SUB:
                    begin
                        yneg = (job_reg.mode == MODE_SUB) ? !job_reg.b_neg : job_reg.b_neg;
                        if (job_reg.a_neg == yneg)
                        begin
                            sneg = job_reg.a_neg;
                            sum  = p1_reg + p2_reg;
                        end
                        else if (p1_reg >= p2_reg)
                        begin
                            sneg = job_reg.a_neg;
                            sum  = p1_reg - p2_reg;
                        end
                        else
                        begin
                            sneg = yneg;
                            sum  = p2_reg - p1_reg;
                        end
                        neg_next = sneg;
                        nm_next  = sum;
                        dm_next  = pd_reg;
                    end
                    MODE_MUL, MODE_DIV:
                    begin
                        neg_next = job_reg.a_neg ^ job_reg.b_neg;
                        nm_next  = p1_reg;
                        dm_next  = pd_reg;
                    end
                    MODE_NEG, MODE_RED:
                    begin
                        neg_next = (job_reg.mode == MODE_NEG) ? !job_reg.a_neg : job_reg.a_neg;
                        nm_next  = {33'd0, job_reg.a_n};
                        dm_next  = {33'd0, job_reg.a_d};
                    end
                    MODE_INC:
                    begin
                        if (!job_reg.a_neg)
                        begin
                            sneg = 1'b0;
                            sum  = {33'd0, job_reg.a_n} + {33'd0, job_reg.a_d};
                        end
                        else if (job_reg.a_n >= job_reg.a_d)
                        begin
                            sneg = 1'b1;
                            sum  = {33'd0, job_reg.a_n - job_reg.a_d};
                        end
                        else
                        begin
                            sneg = 1'b0;
                            sum  = {33'd0, job_reg.a_d - job_reg.a_n};
                        end
                        neg_next = sneg;
                        nm_next  = sum;
                        dm_next  = {33'd0, job_reg.a_d};
                    end
                    MODE_CMP:
                    begin
                        // Signed compare of the two cross products.
                        st_next = ST_OUT;
                        if (job_reg.a_d == '0 || job_reg.b_d == '0)
                        begin
                            res_next.error = ERR_ZDEN;
                        end
                        else if (p1_reg == p2_reg &&
                                 (p1_reg == '0 || job_reg.a_neg == job_reg.b_neg))
                        begin
                            res_next.is_equal = 1'b1;
                        end
                        else if (job_reg.a_neg != job_reg.b_neg)
                        begin
                            res_next.is_less    = job_reg.a_neg;
                            res_next.is_greater = !job_reg.a_neg;
                        end
                        else if (job_reg.a_neg)
                        begin
                            res_next.is_less    = p1_reg > p2_reg;
                            res_next.is_greater = p1_reg < p2_reg;
                        end
                        else
                        begin
                            res_next.is_less    = p1_reg < p2_reg;
                            res_next.is_greater = p1_reg > p2_reg;
                        end
                    end
                    MODE_TOINT:
                    begin
                        neg_next = job_reg.a_neg;
                        nm_next  = {33'd0, job_reg.a_n};
                        dm_next  = {33'd0, job_reg.a_d};
                        if (job_reg.a_d == '0)
                        begin
                            res_next.error = ERR_ZDEN;
                            st_next = ST_OUT;
                        end
                        else
                        begin
                            st_next = ST_DIVN;
                            gx_next = 66'd1;
                        end
                    end
                    default:
                    begin
                        st_next = ST_OUT;
                    end
                endcase
            end
            ST_GCD:
            begin
                if (dm_reg == '0)
                begin
                    res_next.error = ERR_ZDEN;
                    st_next = ST_OUT;
                end
                else
                begin
                    gx_next = nm_reg;
                    gy_next = dm_reg;
                    st_next = ST_GWAIT;
                    dv_go   = 1'b1;
                    dv_a    = nm_reg;
                    dv_b    = dm_reg;
                end
            end
            ST_GWAIT:
            begin
                if (dv_done)
                begin
                    if (dv_r == '0)
                    begin
                        gx_next = gy_reg;
                        st_next = ST_DIVN;
                    end
                    else
                    begin
                        gx_next = gy_reg;
                        gy_next = dv_r;
                        dv_go   = 1'b1;
                        dv_a    = gy_reg;
                        dv_b    = dv_r;
                    end
                end
            end
            ST_DIVN:
            begin
                dv_go   = 1'b1;
                dv_a    = nm_reg;
                dv_b    = gx_reg;
                st_next = ST_WN;
            end
            ST_WN:
            begin
                if (dv_done)
                begin
                    nm_next = dv_q;
                    if (job_reg.mode == MODE_TOINT)
                    begin
                        dv_go   = 1'b1;
                        dv_a    = dv_q;
                        dv_b    = 66'd1;
                        nm_next = dm_reg;
                        // Quotient a_n / a_d: divide again with the real divisor.
                        dv_a    = nm_reg;
                        dv_b    = dm_reg;
                        dm_next = 66'd1;
                        gx_next = dm_reg;
                        st_next = ST_WD;
                    end
                    else
                    begin
                        st_next = ST_DIVD;
                    end
                end
            end
            ST_DIVD:
            begin
                dv_go   = 1'b1;
                dv_a    = dm_reg;
                dv_b    = gx_reg;
                st_next = ST_WD;
            end
            ST_WD:
            begin
                if (dv_done)
                begin
                    st_next = ST_OUT;
                    if (job_reg.mode == MODE_TOINT)
                    begin
                        fneg = (dv_q != '0) && job_reg.a_neg;
                        ovf  = fneg ? (dv_q > lim_pos) : (dv_q > lim_den);
                        if (ovf)
                        begin
                            res_next.error = ERR_OVF;
                        end
                        else
                        begin
                            res_next.res_num = neg32(fneg, dv_q);
                            res_next.res_den = 31'd1;
                        end
                    end
                    else
                    begin
                        fneg = neg_reg && (nm_reg != '0);
                        ovf  = (dv_q > lim_den) ||
                               (fneg ? (nm_reg > lim_pos) : (nm_reg > lim_den));
                        if (ovf)
                        begin
                            res_next.error = ERR_OVF;
                        end
                        else
                        begin
                            res_next.res_num = neg32(fneg, nm_reg);
                            res_next.res_den = dv_q[30:0];
                        end
                    end
                end
            end
            ST_OUT:
            begin
                done_next = 1'b1;
                st_next   = ST_IDLE;
            end
            default:
            begin
                st_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        job_reg <= job_next;
        p1_reg  <= p1_next;
        p2_reg  <= p2_next;
        pd_reg  <= pd_next;
        neg_reg <= neg_next;
        nm_reg  <= nm_next;
        dm_reg  <= dm_next;
        gx_reg  <= gx_next;
        gy_reg  <= gy_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= ST_IDLE;
            done_reg <= 1'b0;
        end
        else
        begin
            st_reg   <= st_next;
            done_reg <= done_next;
        end
    end

    a_onehot_state: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(st_reg)) else $error("state not one-hot");
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> st_reg == ST_IDLE) else $error("pop outside idle");
    a_done_from_out: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(st_reg) == ST_OUT) else $error("result without finish");
    a_flags_onehot0: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $onehot0({result.is_less, result.is_equal, result.is_greater}))
        else $error("more than one compare flag");

endmodule
`default_nettype wire
